// ----- rtl/kva_pkg.sv -----
// Shared constants, types and the note table of the key voice allocator.
`default_nettype none

package kva_pkg;

    localparam int KEYS     = 24;
    localparam int CHANNELS = 8;

    // Field widths of the words on the two channels.
    localparam int KEY_W  = 5;
    localparam int CH_W   = 3;
    localparam int FREQ_W = 10;
    localparam int ACT_W  = 2;

    localparam int KEY_IDX_W = $clog2(KEYS);
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_MAX   = (KEYS > CHANNELS) ? KEYS : CHANNELS;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [CH_W-1:0]     channel;
        logic [FREQ_W-1:0]   note_freq;
        logic                stolen;
        logic [KEY_W-1:0]    stolen_key;
    } t_result;

    // Write commands from the sequencer to the key state store.
    typedef struct packed {
        logic                level_we;
        logic                level;
        logic                claim;
        logic [CH_IDX_W-1:0] claim_ch;
        logic                drop;
        logic                steal;
    } t_store_cmd;

    function automatic logic [FREQ_W-1:0] note_freq_of(input logic [KEY_W-1:0] key);
        logic [FREQ_W-1:0] f;
        case (key)
            5'd0:    f = 10'd261;
            5'd1:    f = 10'd277;
            5'd2:    f = 10'd293;
            5'd3:    f = 10'd311;
            5'd4:    f = 10'd329;
            5'd5:    f = 10'd349;
            5'd6:    f = 10'd369;
            5'd7:    f = 10'd392;
            5'd8:    f = 10'd415;
            5'd9:    f = 10'd440;
            5'd10:   f = 10'd466;
            5'd11:   f = 10'd493;
            5'd12:   f = 10'd523;
            5'd13:   f = 10'd554;
            5'd14:   f = 10'd587;
            5'd15:   f = 10'd622;
            5'd16:   f = 10'd659;
            5'd17:   f = 10'd698;
            5'd18:   f = 10'd739;
            5'd19:   f = 10'd783;
            5'd20:   f = 10'd830;
            5'd21:   f = 10'd880;
            5'd22:   f = 10'd932;
            5'd23:   f = 10'd987;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/kva_ifs.sv -----
// Valid/ready channel interfaces for key samples and voice actions.
`default_nettype none

interface kva_key_if;
    import kva_pkg::*;

    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_index;
    logic             key_down;

    modport source (output valid, output key_index, output key_down, input ready);
    modport sink   (input valid, input key_index, input key_down, output ready);
endinterface

interface kva_voice_if;
    import kva_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [CH_W-1:0]   channel;
    logic [FREQ_W-1:0] note_freq;
    logic              stolen;
    logic [KEY_W-1:0]  stolen_key;

    modport source (output valid, output action, output channel, output note_freq,
                    output stolen, output stolen_key, input ready);
    modport sink   (input valid, input action, input channel, input note_freq,
                    input stolen, input stolen_key, output ready);
endinterface

`default_nettype wire

// ----- rtl/key_voice_allocator.sv -----
// Top level of the key voice allocator: scan sequencer and output register.
`default_nettype none

// Each key word takes its level and compares it with the level the key had
// before. A press or release walks the key table one entry per cycle to
// build the channel busy mask, find the lowest key holding a channel and
// fetch the released key's channel; a press then walks the busy mask one
// channel per cycle looking for the lowest free channel, and steals from the
// lowest held key when none is free. A word with an unchanged level or an
// out-of-range key skips both walks and goes from the key state straight to
// the done state; the single scan read port of the key table is why the walks
// go one entry at a time. A new key word is taken only while the sequencer is
// idle; the result sits in an output register, so the next key word may be
// taken while the previous result still waits.
module key_voice_allocator (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kva_key_if.sink    i_key,
    kva_voice_if.source o_voice
);
    import kva_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_KEYS  = 4'b0010,
        S_CHANS = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [KEY_W-1:0]    r_key, n_key;
    logic                r_down, n_down;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [CHANNELS-1:0] r_busy, n_busy;
    logic                r_vic_found, n_vic_found;
    logic [KEY_IDX_W-1:0] r_vic, n_vic;
    logic [CH_IDX_W-1:0] r_vic_ch, n_vic_ch;
    logic [CH_IDX_W-1:0] r_own_ch, n_own_ch;
    t_result             r_res, n_res;
    t_result             r_out, n_out;
    logic                r_out_valid, n_out_valid;

    t_store_cmd          s_cmd;
    logic                w_last_level;
    logic                w_key_held;
    logic                w_scan_held;
    logic [CH_IDX_W-1:0] w_scan_ch;

    logic [KEY_IDX_W-1:0] w_key_idx;
    logic [KEY_IDX_W-1:0] w_scan_idx;
    logic [CH_IDX_W-1:0]  w_chan_idx;
    logic                 w_in_range;
    logic                 w_changed;
    logic [CH_IDX_W-1:0]  w_own_ch;

    assign w_key_idx  = KEY_IDX_W'(r_key);
    assign w_scan_idx = KEY_IDX_W'(r_cnt);
    assign w_chan_idx = CH_IDX_W'(r_cnt);
    assign w_in_range = (32'(r_key) < 32'(KEYS));
    assign w_changed  = (r_down != w_last_level);
    assign w_own_ch   = (w_scan_idx == w_key_idx) ? w_scan_ch : r_own_ch;

    kva_key_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key        (w_key_idx),
        .i_scan       (w_scan_idx),
        .i_victim     (r_vic),
        .i_cmd        (s_cmd),
        .o_last_level (w_last_level),
        .o_key_held   (w_key_held),
        .o_scan_held  (w_scan_held),
        .o_scan_ch    (w_scan_ch)
    );

    assign i_key.ready        = (r_state == S_IDLE);
    assign o_voice.valid      = r_out_valid;
    assign o_voice.action     = r_out.action;
    assign o_voice.channel    = r_out.channel;
    assign o_voice.note_freq  = r_out.note_freq;
    assign o_voice.stolen     = r_out.stolen;
    assign o_voice.stolen_key = r_out.stolen_key;

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_down      = r_down;
        n_cnt       = r_cnt;
        n_busy      = r_busy;
        n_vic_found = r_vic_found;
        n_vic       = r_vic;
        n_vic_ch    = r_vic_ch;
        n_own_ch    = r_own_ch;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        s_cmd       = '0;

        if (r_out_valid && o_voice.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_key.valid) begin
                    n_key       = i_key.key_index;
                    n_down      = i_key.key_down;
                    n_cnt       = '0;
                    n_busy      = '0;
                    n_vic_found = 1'b0;
                    n_vic       = '0;
                    n_vic_ch    = '0;
                    n_own_ch    = '0;
                    n_res       = '0;
                    n_res.action = ACT_NONE;
                    n_state     = S_KEYS;
                end
            end

            S_KEYS: begin
                if (!w_in_range || !w_changed) begin
                    n_state = S_DONE;
                end else begin
                    if (w_scan_held) begin
                        n_busy = r_busy | (CHANNELS'(1) << w_scan_ch);
                        if (!r_vic_found) begin
                            n_vic_found = 1'b1;
                            n_vic       = w_scan_idx;
                            n_vic_ch    = w_scan_ch;
                        end
                    end
                    n_own_ch = w_own_ch;
                    if (r_cnt == CNT_W'(KEYS - 1)) begin
                        if (r_down) begin
                            n_cnt   = '0;
                            n_state = S_CHANS;
                        end else begin
                            s_cmd.level_we = 1'b1;
                            s_cmd.level    = 1'b0;
                            // A key whose channel was stolen releases silently.
                            if (w_key_held) begin
                                s_cmd.drop    = 1'b1;
                                n_res.action  = ACT_STOP;
                                n_res.channel = CH_W'(w_own_ch);
                            end
                            n_state = S_DONE;
                        end
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end

            S_CHANS: begin
                if (!r_busy[w_chan_idx]) begin
                    s_cmd.level_we  = 1'b1;
                    s_cmd.level     = 1'b1;
                    s_cmd.claim     = 1'b1;
                    s_cmd.claim_ch  = w_chan_idx;
                    n_res.action    = ACT_START;
                    n_res.channel   = CH_W'(w_chan_idx);
                    n_res.note_freq = note_freq_of(r_key);
                    n_state         = S_DONE;
                end else if (r_cnt == CNT_W'(CHANNELS - 1)) begin
                    s_cmd.level_we = 1'b1;
                    s_cmd.level    = 1'b1;
                    if (r_vic_found) begin
                        s_cmd.steal      = 1'b1;
                        s_cmd.claim      = 1'b1;
                        s_cmd.claim_ch   = r_vic_ch;
                        n_res.action     = ACT_START;
                        n_res.channel    = CH_W'(r_vic_ch);
                        n_res.note_freq  = note_freq_of(r_key);
                        n_res.stolen     = 1'b1;
                        n_res.stolen_key = KEY_W'(r_vic);
                    end
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end

            S_DONE: begin
                if (!r_out_valid || o_voice.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_down      <= n_down;
        r_cnt       <= n_cnt;
        r_busy      <= n_busy;
        r_vic_found <= n_vic_found;
        r_vic       <= n_vic;
        r_vic_ch    <= n_vic_ch;
        r_own_ch    <= n_own_ch;
        r_res       <= n_res;
        r_out       <= n_out;
    end

`ifndef SYNTHESIS
    a_none_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_NONE) |->
            (r_out.channel == '0 && r_out.note_freq == '0 && r_out.stolen == 1'b0))
        else $error("empty result carries a channel, frequency or steal");

    a_steal_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stolen) |-> (r_out.action == ACT_START))
        else $error("steal reported without a start");

    a_stop_is_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action == ACT_STOP) |->
            (r_out.note_freq == '0 && r_out.stolen == 1'b0))
        else $error("stop carries a frequency or a steal");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_key.valid && i_key.ready) |=> (r_state == S_KEYS && r_cnt == '0))
        else $error("accepted key word did not start the key scan");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_out_valid || o_voice.ready)) |=>
            (r_out_valid && r_state == S_IDLE))
        else $error("finished word was not moved to the output register");
`endif

endmodule

`default_nettype wire

// ----- rtl/kva_key_store.sv -----
// Per-key state: last level, held flag and held channel, with one scan read port.
`default_nettype none

module kva_key_store (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [kva_pkg::KEY_IDX_W-1:0]  i_key,
    input  wire logic [kva_pkg::KEY_IDX_W-1:0]  i_scan,
    input  wire logic [kva_pkg::KEY_IDX_W-1:0]  i_victim,
    input  wire kva_pkg::t_store_cmd            i_cmd,
    output logic                                o_last_level,
    output logic                                o_key_held,
    output logic                                o_scan_held,
    output logic [kva_pkg::CH_IDX_W-1:0]        o_scan_ch
);
    import kva_pkg::*;

    logic [KEYS-1:0]     r_last_level;
    logic [KEYS-1:0]     r_held;
    logic [CH_IDX_W-1:0] r_held_ch [KEYS];

    assign o_last_level = r_last_level[i_key];
    assign o_key_held   = r_held[i_key];
    assign o_scan_held  = r_held[i_scan];
    assign o_scan_ch    = r_held_ch[i_scan];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level <= '0;
            r_held       <= '0;
        end else begin
            if (i_cmd.level_we) begin
                r_last_level[i_key] <= i_cmd.level;
            end
            if (i_cmd.steal) begin
                r_held[i_victim] <= 1'b0;
            end
            if (i_cmd.drop) begin
                r_held[i_key] <= 1'b0;
            end
            if (i_cmd.claim) begin
                r_held[i_key] <= 1'b1;
            end
        end
    end

    // The channel number is only looked at while its held flag is set.
    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            r_held_ch[i_key] <= i_cmd.claim_ch;
        end
    end

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the key voice allocator: directed table, then random key words.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kva_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PER_PH  = 275;
    localparam int PLAN_ROWS    = 23;
    localparam int MAX_REPORTS  = 10;

    // One row of the directed plan; want is used only when typed is set.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             down;
        logic             typed;
        t_result          want;
    } t_key_row;

    localparam t_result NO_ACTION = '{ACT_NONE, 3'd0, 10'd0, 1'b0, 5'd0};

    localparam t_key_row KEY_PLAN [PLAN_ROWS] = '{
        '{5'd0,  1'b1, 1'b1, '{ACT_START, 3'd0, 10'd261, 1'b0, 5'd0}},
        '{5'd23, 1'b1, 1'b1, '{ACT_START, 3'd1, 10'd987, 1'b0, 5'd0}},
        '{5'd23, 1'b0, 1'b1, '{ACT_STOP,  3'd1, 10'd0,   1'b0, 5'd0}},
        '{5'd24, 1'b1, 1'b1, NO_ACTION},
        '{5'd31, 1'b1, 1'b1, NO_ACTION},
        '{5'd5,  1'b0, 1'b1, NO_ACTION},
        '{5'd1,  1'b1, 1'b0, NO_ACTION},
        '{5'd2,  1'b1, 1'b0, NO_ACTION},
        '{5'd3,  1'b1, 1'b0, NO_ACTION},
        '{5'd4,  1'b1, 1'b0, NO_ACTION},
        '{5'd5,  1'b1, 1'b0, NO_ACTION},
        '{5'd6,  1'b1, 1'b0, NO_ACTION},
        '{5'd7,  1'b1, 1'b0, NO_ACTION},
        // Every channel is busy now, so key 8 takes the channel of key 0.
        '{5'd8,  1'b1, 1'b1, '{ACT_START, 3'd0, 10'd415, 1'b1, 5'd0}},
        '{5'd0,  1'b0, 1'b1, NO_ACTION},
        '{5'd0,  1'b1, 1'b0, NO_ACTION},
        '{5'd9,  1'b1, 1'b0, NO_ACTION},
        '{5'd9,  1'b0, 1'b0, NO_ACTION},
        '{5'd23, 1'b1, 1'b0, NO_ACTION},
        '{5'd23, 1'b1, 1'b1, NO_ACTION},
        '{5'd31, 1'b0, 1'b1, NO_ACTION},
        '{5'd16, 1'b1, 1'b0, NO_ACTION},
        '{5'd15, 1'b1, 1'b0, NO_ACTION}
    };

    localparam logic [FREQ_W-1:0] KEY_HZ [24] = '{
        10'd261, 10'd277, 10'd293, 10'd311, 10'd329, 10'd349,
        10'd369, 10'd392, 10'd415, 10'd440, 10'd466, 10'd493,
        10'd523, 10'd554, 10'd587, 10'd622, 10'd659, 10'd698,
        10'd739, 10'd783, 10'd830, 10'd880, 10'd932, 10'd987
    };

    logic clk = 1'b0;
    logic rst_n;

    kva_key_if   key_ch ();
    kva_voice_if voice_ch ();

    key_voice_allocator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_key   (key_ch),
        .o_voice (voice_ch)
    );

    // Allocator shadow state.
    bit              key_level [KEYS];
    bit              key_owns  [KEYS];
    logic [CH_W-1:0] key_chan  [KEYS];

    t_result voice_due [$];

    int send_idle_pct;
    int recv_idle_pct;
    bit burst_phase;
    bit hold_done = 1'b0;
    int hold_left = 0;

    int mismatches = 0;
    int words_sent;
    int n_start = 0;
    int n_stop = 0;
    int n_none = 0;
    int n_steal = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic t_result predict_voice(input logic [KEY_W-1:0] key, input logic down);
        t_result         r;
        bit              busy [CHANNELS];
        bit              got;
        logic [CH_W-1:0] pick;
        r = NO_ACTION;
        got = 1'b0;
        pick = '0;
        if (key < KEYS) begin
            if (down && !key_level[key]) begin
                for (int c = 0; c < CHANNELS; c++) busy[c] = 1'b0;
                for (int k = 0; k < KEYS; k++) begin
                    if (key_owns[k]) busy[key_chan[k]] = 1'b1;
                end
                for (int c = 0; c < CHANNELS; c++) begin
                    if (!got && !busy[c]) begin
                        got = 1'b1;
                        pick = c[CH_W-1:0];
                    end
                end
                if (!got) begin
                    for (int k = 0; k < KEYS; k++) begin
                        if (!got && key_owns[k]) begin
                            got = 1'b1;
                            pick = key_chan[k];
                            key_owns[k] = 1'b0;
                            key_chan[k] = '0;
                            r.stolen = 1'b1;
                            r.stolen_key = k[KEY_W-1:0];
                        end
                    end
                end
                if (got) begin
                    key_owns[key] = 1'b1;
                    key_chan[key] = pick;
                    r.action = ACT_START;
                    r.channel = pick;
                    r.note_freq = (key < 24) ? KEY_HZ[key] : '0;
                end
            end else if (!down && key_level[key] && key_owns[key]) begin
                r.action = ACT_STOP;
                r.channel = key_chan[key];
                key_owns[key] = 1'b0;
                key_chan[key] = '0;
            end
            key_level[key] = down;
        end
        return r;
    endfunction

    // Offers one key word, waits for it to be taken, then queues its expected voice word.
    task automatic offer_word(input logic [KEY_W-1:0] key, input logic down,
                              input logic typed, input t_result want);
        t_result guess;
        while ($urandom_range(99) < send_idle_pct) begin
            key_ch.valid <= 1'b0;
            @(posedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.key_index <= key;
        key_ch.key_down <= down;
        @(posedge clk);
        while (!key_ch.ready) @(posedge clk);
        guess = predict_voice(key, down);
        voice_due.push_back(typed ? want : guess);
        words_sent++;
    endtask

    // Mostly level changes on valid keys, so that channels fill and get stolen.
    task automatic run_random(input int count);
        int               pick;
        logic [KEY_W-1:0] k;
        logic             d;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                k = KEY_W'($urandom_range(KEYS - 1));
                d = ($urandom_range(99) < 75) ? !key_level[k] : key_level[k];
            end else if (pick < 95) begin
                k = KEY_W'($urandom_range(31, KEYS));
                d = 1'($urandom_range(1));
            end else begin
                k = KEY_W'($urandom_range(31));
                d = 1'($urandom_range(1));
            end
            offer_word(k, d, 1'b0, NO_ACTION);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off at the start of the burst phase.
    always @(posedge clk) begin
        if (!rst_n) begin
            voice_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            voice_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (burst_phase && !hold_done) begin
            voice_ch.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            voice_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        t_result seen;
        t_result want;
        if (rst_n && voice_ch.valid && voice_ch.ready) begin
            seen = '{t_action'(voice_ch.action), voice_ch.channel, voice_ch.note_freq,
                     voice_ch.stolen, voice_ch.stolen_key};
            case (seen.action)
                ACT_START: n_start++;
                ACT_STOP:  n_stop++;
                default:   n_none++;
            endcase
            if (seen.stolen) n_steal++;
            if (voice_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected voice word: act=%0d ch=%0d freq=%0d stolen=%0d key=%0d",
                             seen.action, seen.channel, seen.note_freq, seen.stolen,
                             seen.stolen_key);
            end else begin
                want = voice_due.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"voice word mismatch: expected act=%0d ch=%0d freq=%0d ",
                                  "stolen=%0d key=%0d, got act=%0d ch=%0d freq=%0d ",
                                  "stolen=%0d key=%0d"},
                                 want.action, want.channel, want.note_freq, want.stolen,
                                 want.stolen_key, seen.action, seen.channel, seen.note_freq,
                                 seen.stolen, seen.stolen_key);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        key_ch.valid = 1'b0;
        key_ch.key_index = '0;
        key_ch.key_down = 1'b0;
        words_sent = 0;
        burst_phase = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 55;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
            offer_word(KEY_PLAN[i].key, KEY_PLAN[i].down, KEY_PLAN[i].typed, KEY_PLAN[i].want);
        run_random(RAND_PER_PH);

        send_idle_pct = 55;
        recv_idle_pct = 34;
        run_random(RAND_PER_PH);

        // No idling on either side; the receiver's hold-off backs the block up.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        burst_phase = 1'b1;
        run_random(RAND_PER_PH);

        @(posedge clk);
        key_ch.valid <= 1'b0;
        while (voice_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d key words across three idle mixes and one long output hold-off",
                 words_sent);
        $display("voice words: %0d starts (%0d stolen), %0d stops, %0d with no action",
                 n_start, n_steal, n_stop, n_none);
        if (mismatches == 0 && voice_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
